### rtl/core/circle_octant_rasterizer_defines.svh
// Assertion macros for the circle octant rasterizer checker.
// No dependencies; included by the checker file only.
`ifndef CIRCLE_OCTANT_RASTERIZER_DEFINES_SVH
`define CIRCLE_OCTANT_RASTERIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define COR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circle rasterizer check failed");

// Next-cycle implication, disabled while reset is held
`define COR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circle rasterizer check failed");

// Next-cycle implication that is checked through reset as well
`define COR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("circle rasterizer check failed");

`endif

### rtl/core/cor_pkg.sv
// Shared types and constants for the circle octant rasterizer.
// No dependencies; imported by every module of the block.
package cor_pkg;

    // coordinate, decision and point widths
    localparam int CoordBits = 10;
    localparam int RadBits   = 9;
    localparam int DecBits   = CoordBits + 3;
    localparam int PtBits    = 12;

    // stream word widths
    localparam int InDataBits  = 32;
    localparam int OutDataBits = 24;

    // job queue between front and back
    localparam int QDepth = 2;

    // input kind carried on tuser
    typedef enum logic {
        FuncStart = 1'b0,
        FuncStep  = 1'b1
    } t_func;

    // one step of work: centre, current offsets and end-of-circle flag
    typedef struct packed {
        logic [CoordBits-1:0] cx;
        logic [CoordBits-1:0] cy;
        logic [CoordBits-1:0] ox;
        logic [CoordBits-1:0] oy;
        logic                 done;
    } t_job;

endpackage

### rtl/core/circle_octant_rasterizer.sv
// Top level of the Bresenham circle generator.
// Depends on cor_pkg, cor_front, cor_queue and cor_back.
//
// Input stream (s_axis): tuser selects start (0) or step (1); tdata holds
// centre x, centre y and radius. A start word loads a new circle and gives
// no output. A step word on an active circle gives eight points; a step on
// an idle circle is swallowed.
// Output stream (m_axis): tdata holds point x and y (12-bit two's
// complement), tlast marks the eighth point of a step, tuser marks the
// final point of the circle.
// The first point of a step passes through the job queue and then the
// output register before it is valid. Throughput: one point per cycle
// while the receiver is ready and a job is waiting in the queue.
// The front end updates the circle state on acceptance and hands a job to
// a two-entry queue; s_axis_tready drops only while that queue is full.
// When the receiver stalls, the held point stays and the queue fills.
// Synchronous active-low reset returns the circle to idle and empties the
// queue and the output stage.
module circle_octant_rasterizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [9:0] center_x, [19:10] center_y, [28:20] circle_radius, rest zero
    input  logic [cor_pkg::InDataBits-1:0]  s_axis_tdata,
    // [0] func
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [11:0] point_x, [23:12] point_y
    output logic [cor_pkg::OutDataBits-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    // [0] circle_done
    output logic                            m_axis_tuser
);
    import cor_pkg::*;

    logic                 accept;
    logic                 push, pop, full, job_valid;
    t_job                 push_job, head_job;
    t_func                func;
    logic [PtBits-1:0]    pt_x, pt_y;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !full;
    assign func          = t_func'(s_axis_tuser);

    // front: word acceptance and circle state
    cor_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_func     (func),
        .i_center_x (s_axis_tdata[CoordBits-1:0]),
        .i_center_y (s_axis_tdata[2*CoordBits-1:CoordBits]),
        .i_radius   (s_axis_tdata[2*CoordBits+RadBits-1:2*CoordBits]),
        .o_push     (push),
        .o_job      (push_job)
    );

    // job queue
    cor_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (job_valid),
        .o_job   (head_job)
    );

    // back: point expansion
    cor_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_point_x   (pt_x),
        .o_point_y   (pt_y),
        .o_last      (m_axis_tlast),
        .o_done      (m_axis_tuser)
    );

    assign m_axis_tdata = {pt_y, pt_x};

endmodule

### rtl/core/cor_front.sv
// Front end: accepts start/step words, keeps the Bresenham state and
// issues one job per active step. Depends on cor_pkg.
module cor_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  cor_pkg::t_func                i_func,
    input  logic [cor_pkg::CoordBits-1:0] i_center_x,
    input  logic [cor_pkg::CoordBits-1:0] i_center_y,
    input  logic [cor_pkg::RadBits-1:0]   i_radius,
    output logic                          o_push,
    output cor_pkg::t_job                 o_job
);
    import cor_pkg::*;

    logic                        r_active;
    logic [CoordBits-1:0]        r_cx, r_cy, r_ox, r_oy;
    logic signed [DecBits-1:0]   r_dec;

    logic                        dec_le0;
    logic                        done;
    logic [DecBits-1:0]          diff;
    logic signed [DecBits-1:0]   n_dec;
    logic [CoordBits-1:0]        n_oy;

    // decision update and end-of-circle test from current offsets
    always_comb begin
        dec_le0 = r_dec[DecBits-1] || (r_dec == '0);
        diff    = {3'b000, r_ox} - {3'b000, r_oy};
        n_oy    = r_oy;
        if (dec_le0) begin
            done  = (r_ox >= r_oy);
            n_dec = r_dec + {1'b0, r_ox, 2'b00} + DecBits'(6);
        end else begin
            done  = (({1'b0, r_ox} + (CoordBits+1)'(1)) >= {1'b0, r_oy});
            n_dec = r_dec + {diff[DecBits-3:0], 2'b00} + DecBits'(10);
            if (!done) begin
                n_oy = r_oy - CoordBits'(1);
            end
        end
    end

    assign o_push = i_accept && (i_func == FuncStep) && r_active;
    assign o_job  = '{cx: r_cx, cy: r_cy, ox: r_ox, oy: r_oy, done: done};

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_ox     <= '0;
            r_oy     <= '0;
            r_dec    <= '0;
        end else if (i_accept) begin
            if (i_func == FuncStart) begin
                r_active <= 1'b1;
                r_cx     <= i_center_x;
                r_cy     <= i_center_y;
                r_ox     <= '0;
                r_oy     <= {1'b0, i_radius};
                r_dec    <= DecBits'(3) - {3'b000, i_radius, 1'b0};
            end else if (r_active) begin
                r_dec <= n_dec;
                if (done) begin
                    r_active <= 1'b0;
                end else begin
                    r_ox <= r_ox + CoordBits'(1);
                    r_oy <= n_oy;
                end
            end
        end
    end

endmodule

### rtl/core/cor_queue.sv
// Short job queue between front and back ends.
// Depends on cor_pkg for the job type and depth.
module cor_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cor_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output cor_pkg::t_job o_job
);
    import cor_pkg::*;

    localparam int PtrBits = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int CntBits = $clog2(QDepth + 1);

    t_job               r_mem [QDepth];
    logic [PtrBits-1:0] r_wr, r_rd;
    logic [CntBits-1:0] r_cnt;

    assign o_full  = (r_cnt == CntBits'(QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrBits'(QDepth - 1)) ? '0 : r_wr + PtrBits'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrBits'(QDepth - 1)) ? '0 : r_rd + PtrBits'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CntBits'(1);
                2'b01:   r_cnt <= r_cnt - CntBits'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/core/cor_back.sv
// Back end: expands one job into eight symmetric points, one per cycle while the receiver is ready,
// through a registered output stage. Depends on cor_pkg.
module cor_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    input  cor_pkg::t_job              i_job,
    output logic                       o_pop,
    output logic                       o_tvalid,
    input  logic                       i_tready,
    output logic [cor_pkg::PtBits-1:0] o_point_x,
    output logic [cor_pkg::PtBits-1:0] o_point_y,
    output logic                       o_last,
    output logic                       o_done
);
    import cor_pkg::*;

    logic [2:0]          r_k;
    logic                r_tvalid;
    logic [PtBits-1:0]   r_px, r_py;
    logic                r_last, r_done;

    logic                load;
    logic [PtBits-1:0]   a, b, cx, cy;
    logic [PtBits-1:0]   n_px, n_py;

    // point k: bit 2 swaps the offsets, bit 0 negates x side, bit 1 y side
    always_comb begin
        cx   = PtBits'(i_job.cx);
        cy   = PtBits'(i_job.cy);
        a    = r_k[2] ? PtBits'(i_job.oy) : PtBits'(i_job.ox);
        b    = r_k[2] ? PtBits'(i_job.ox) : PtBits'(i_job.oy);
        n_px = r_k[0] ? cx - a : cx + a;
        n_py = r_k[1] ? cy - b : cy + b;
    end

    assign load  = i_job_valid && (!r_tvalid || i_tready);
    assign o_pop = load && (r_k == 3'd7);

    // point counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= '0;
            r_tvalid <= 1'b0;
        end else if (load) begin
            r_k      <= r_k + 3'd1;
            r_tvalid <= 1'b1;
        end else if (i_tready) begin
            r_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_px   <= n_px;
            r_py   <= n_py;
            r_last <= (r_k == 3'd7);
            r_done <= (r_k == 3'd7) && i_job.done;
        end
    end

    assign o_tvalid  = r_tvalid;
    assign o_point_x = r_px;
    assign o_point_y = r_py;
    assign o_last    = r_last;
    assign o_done    = r_done;

endmodule

### rtl/core/cor_checker.sv
// Port-level checks for the circle rasterizer, bound to the top level.
// Depends on cor_pkg and circle_octant_rasterizer_defines.svh.
`include "circle_octant_rasterizer_defines.svh"

module cor_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [cor_pkg::OutDataBits-1:0] m_axis_tdata,
    input logic                            m_axis_tlast,
    input logic                            m_axis_tuser
);
    import cor_pkg::*;

    // end of circle only on the closing point of a step
    `COR_ASSERT_NOW(a_done_on_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast)

    // a stalled word holds
    `COR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // the eight points of a step follow without gaps
    `COR_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)

    // reset empties the output stage
    `COR_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule

bind circle_octant_rasterizer cor_checker u_cor_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

### sim/cor_point_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the circle octant rasterizer. It watches both stream channels,
// works out the eight points of each active step word and compares each point on exit.
// Depends on cor_pkg; instantiated by tb_circle_octant_rasterizer.
module cor_point_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    // [9:0] center_x, [19:10] center_y, [28:20] circle_radius, rest zero
    input  logic [cor_pkg::InDataBits-1:0]  i_in_data,
    // [0] func
    input  logic                            i_in_user,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    // [11:0] point_x, [23:12] point_y
    input  logic [cor_pkg::OutDataBits-1:0] i_out_data,
    input  logic                            i_out_last,
    // [0] circle_done
    input  logic                            i_out_user,
    output int                              o_fail_count,
    output int                              o_pending
);
    import cor_pkg::*;

    // one emitted pixel as it should leave the block
    typedef struct packed {
        logic [PtBits-1:0] px;
        logic [PtBits-1:0] py;
        logic              last;
        logic              done;
    } t_pixel;

    t_pixel                    pending_points[$];
    t_pixel                    want;
    logic [CoordBits-1:0]      circ_cx;
    logic [CoordBits-1:0]      circ_cy;
    logic [CoordBits-1:0]      circ_ox;
    logic [CoordBits-1:0]      circ_oy;
    logic signed [DecBits-1:0] circ_dec;
    logic                      circ_active;
    int                        mismatches   = 0;
    int                        points_owed  = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = points_owed;

    task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                   input logic [31:0] got_val);
        $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, exp_val,
                 got_val);
        mismatches++;
    endtask

    // Advance the circle by one accepted input word and queue its points
    task automatic rasterise_word(input t_func func, input logic [InDataBits-1:0] data);
        int     x;
        int     y;
        int     cx;
        int     cy;
        int     d;
        logic   fin;
        int     ptx[8];
        int     pty[8];
        t_pixel p;
        if (func == FuncStart) begin
            circ_cx     = data[CoordBits-1:0];
            circ_cy     = data[2*CoordBits-1:CoordBits];
            circ_ox     = '0;
            circ_oy     = CoordBits'(data[2*CoordBits+RadBits-1:2*CoordBits]);
            d           = 3 - 2 * int'(circ_oy);
            circ_dec    = d[DecBits-1:0];
            circ_active = 1'b1;
            return;
        end
        // a step on an idle circle is swallowed
        if (!circ_active) return;
        cx = int'(circ_cx);
        cy = int'(circ_cy);
        x  = int'(circ_ox);
        y  = int'(circ_oy);
        ptx[0] = cx + x; pty[0] = cy + y;
        ptx[1] = cx - x; pty[1] = cy + y;
        ptx[2] = cx + x; pty[2] = cy - y;
        ptx[3] = cx - x; pty[3] = cy - y;
        ptx[4] = cx + y; pty[4] = cy + x;
        ptx[5] = cx - y; pty[5] = cy + x;
        ptx[6] = cx + y; pty[6] = cy - x;
        ptx[7] = cx - y; pty[7] = cy - x;
        // midpoint decision; end of circle judged on the offsets before update
        d = int'(circ_dec);
        if (d <= 0) begin
            fin = (x >= y);
            d   = d + 4 * x + 6;
        end else begin
            fin = (x + 1 >= y);
            d   = d + 4 * (x - y) + 10;
            if (!fin) y = y - 1;
        end
        x        = x + 1;
        circ_dec = d[DecBits-1:0];
        if (fin) begin
            circ_active = 1'b0;
        end else begin
            circ_ox = x[CoordBits-1:0];
            circ_oy = y[CoordBits-1:0];
        end
        for (int k = 0; k < 8; k++) begin
            p.px   = ptx[k][PtBits-1:0];
            p.py   = pty[k][PtBits-1:0];
            p.last = (k == 7);
            p.done = (k == 7) && fin;
            pending_points.push_back(p);
        end
    endtask

    // Outputs are checked before the input word of the same edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            circ_cx     = '0;
            circ_cy     = '0;
            circ_ox     = '0;
            circ_oy     = '0;
            circ_dec    = '0;
            circ_active = 1'b0;
            pending_points.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_points.size() == 0) begin
                    report_mismatch("unexpected point", '0, 32'(i_out_data));
                end else begin
                    want = pending_points.pop_front();
                    if (want.px !== i_out_data[PtBits-1:0])
                        report_mismatch("point_x", 32'(want.px),
                                        32'(i_out_data[PtBits-1:0]));
                    if (want.py !== i_out_data[2*PtBits-1:PtBits])
                        report_mismatch("point_y", 32'(want.py),
                                        32'(i_out_data[2*PtBits-1:PtBits]));
                    if (want.last !== i_out_last)
                        report_mismatch("last_of_step", 32'(want.last), 32'(i_out_last));
                    if (want.done !== i_out_user)
                        report_mismatch("circle_done", 32'(want.done), 32'(i_out_user));
                end
            end
            if (i_in_valid && i_in_ready)
                rasterise_word(t_func'(i_in_user), i_in_data);
        end
        points_owed = pending_points.size();
    end

endmodule

### sim/tb_circle_octant_rasterizer.sv
`timescale 1ns / 1ps
// Testbench top for the circle octant rasterizer: drives start and step words
// with bursty timing and a stalling receiver, and gives the verdict.
// Depends on cor_pkg, circle_octant_rasterizer and cor_point_checker.
module tb_circle_octant_rasterizer;
    import cor_pkg::*;

    localparam int QuietLimit = 1000;
    localparam int WordTarget = 220;

    // receiver stall patterns
    typedef enum int {
        RxFree,
        RxRandom,
        RxBursty,
        RxToggle
    } t_rx_mode;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [9:0] center_x, [19:10] center_y, [28:20] circle_radius, rest zero
    logic [InDataBits-1:0]  s_axis_tdata  = '0;
    // [0] func
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [11:0] point_x, [23:12] point_y
    logic [OutDataBits-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    // [0] circle_done
    logic                   m_axis_tuser;

    int       fail_count;
    int       points_owed;
    int       burst_left   = 0;
    int       words_sent   = 0;
    int       quiet_cycles = 0;
    int       rx_phase     = 0;
    int       stall_left   = 0;
    t_rx_mode rx_mode      = RxFree;

    always #1 i_clk = ~i_clk;

    circle_octant_rasterizer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    cor_point_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (points_owed)
    );

    // Receiver: picks a new random stall pattern whenever its phase counter wraps
    always @(negedge i_clk) begin
        rx_phase++;
        if (rx_phase == 80) begin
            rx_phase = 0;
            rx_mode  = t_rx_mode'($urandom_range(0, 3));
        end
        case (rx_mode)
            RxFree: begin
                m_axis_tready = 1'b1;
            end
            RxRandom: begin
                m_axis_tready = ($urandom_range(0, 3) != 0);
            end
            RxBursty: begin
                if (stall_left > 0) begin
                    m_axis_tready = 1'b0;
                    stall_left--;
                end else begin
                    m_axis_tready = 1'b1;
                    if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
                end
            end
            default: begin
                m_axis_tready = ~m_axis_tready;
            end
        endcase
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    // One word on s_axis, in bursts with random gaps between them
    task automatic send_word(input t_func func, input logic [CoordBits-1:0] cx,
                             input logic [CoordBits-1:0] cy, input logic [RadBits-1:0] rad);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tuser  = func;
        s_axis_tdata  = {3'b000, rad, cy, cx};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Start word then a run of step words; step payload is junk the block ignores
    task automatic trace_circle(input logic [CoordBits-1:0] cx, input logic [CoordBits-1:0] cy,
                                input logic [RadBits-1:0] rad, input int steps);
        send_word(FuncStart, cx, cy, rad);
        for (int i = 0; i < steps; i++)
            send_word(FuncStep, CoordBits'($urandom_range(0, 1023)),
                      CoordBits'($urandom_range(0, 1023)), RadBits'($urandom_range(0, 511)));
        words_sent += steps + 1;
    endtask

    // Hold the sender off until every queued point has left
    task automatic drain_points();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (points_owed != 0) @(negedge i_clk);
    endtask

    initial begin
        int rad;
        int span;
        int pick;
        bit paused;
        paused = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: step on idle, zero radius, wrap at the edges, restart while active
        send_word(FuncStep, 10'd1023, 10'd1023, 9'd511);
        words_sent++;
        trace_circle(10'd0, 10'd0, 9'd0, 2);
        trace_circle(10'd1023, 10'd1023, 9'd511, 3);
        trace_circle(10'd0, 10'd0, 9'd511, 3);
        trace_circle(10'd512, 10'd300, 9'd1, 2);
        trace_circle(10'd1023, 10'd0, 9'd2, 3);
        trace_circle(10'd0, 10'd1023, 9'd3, 1);
        trace_circle(10'd341, 10'd682, 9'd4, 4);
        drain_points();

        // random circles, mostly small and run to the end, some cut short
        while (words_sent < WordTarget) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                send_word(FuncStep, CoordBits'($urandom_range(0, 1023)),
                          CoordBits'($urandom_range(0, 1023)),
                          RadBits'($urandom_range(0, 511)));
                words_sent++;
            end else if (pick == 1) begin
                rad = $urandom_range(256, 511);
                trace_circle(CoordBits'($urandom_range(0, 1023)),
                             CoordBits'($urandom_range(0, 1023)), RadBits'(rad),
                             $urandom_range(1, 5));
            end else begin
                rad  = (pick < 5) ? $urandom_range(25, 70) : $urandom_range(0, 24);
                span = rad * 181 / 256 + 2;
                if ($urandom_range(0, 4) == 0) span = $urandom_range(1, span);
                trace_circle(CoordBits'($urandom_range(0, 1023)),
                             CoordBits'($urandom_range(0, 1023)), RadBits'(rad), span);
            end
            if (!paused && words_sent > WordTarget / 2) begin
                paused = 1'b1;
                drain_points();
            end
        end

        drain_points();
        repeat (30) @(negedge i_clk);
        if (fail_count == 0 && points_owed == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
